// ===== rtl/core/gsg_pkg.sv =====
package gsg_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 65535;

    // Row counters run a few rows past the frame while the pipeline drains.
    localparam int ROW_W = 17;

    localparam logic [10:0] WIDTH_RESET  = 11'd1024;
    localparam logic [15:0] HEIGHT_RESET = 16'd1024;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_idx;

    // 90 degrees in the accumulator scale (Q.4 with 8 guard bits).
    localparam logic signed [21:0] ANG_Q90 = 22'sd368827;
    localparam logic signed [12:0] ANG_MAX = 13'sd2882;

    // Slightly below 2^32 / 159, used to divide the blur sum by 159.
    localparam logic [24:0] RECIP_159 = 25'd27012031;
    localparam logic [7:0]  DIV_159   = 8'd159;

    typedef struct packed {
        logic rd;
        logic raw_wr;
        logic col;
        logic sum;
        logic mul;
        logic cor;
        logic bwr;
        logic sob;
        logic cinit;
        logic cord;
        logic fin;
        logic adv;
    } t_cmd;

    typedef struct packed {
        logic blur_on;
        logic sob_on;
        logic it_done;
    } t_sts;

    function automatic logic [3:0] gauss_w(input int e, input int k);
        logic [3:0] w;
        w = 4'd0;
        case (e * 5 + k)
            0, 4, 20, 24:                 w = 4'd2;
            1, 3, 5, 9, 15, 19, 21, 23:   w = 4'd4;
            2, 10, 14, 22:                w = 4'd5;
            6, 8, 16, 18:                 w = 4'd9;
            7, 11, 13, 17:                w = 4'd12;
            12:                           w = 4'd15;
            default:                      w = 4'd0;
        endcase
        return w;
    endfunction

    function automatic logic [17:0] atan_tab(input logic [3:0] i);
        logic [17:0] a;
        case (i)
            4'd0:    a = 18'd184413;
            4'd1:    a = 18'd108866;
            4'd2:    a = 18'd57522;
            4'd3:    a = 18'd29199;
            4'd4:    a = 18'd14656;
            4'd5:    a = 18'd7335;
            4'd6:    a = 18'd3668;
            4'd7:    a = 18'd1834;
            4'd8:    a = 18'd917;
            4'd9:    a = 18'd459;
            4'd10:   a = 18'd229;
            4'd11:   a = 18'd115;
            4'd12:   a = 18'd57;
            4'd13:   a = 18'd29;
            4'd14:   a = 18'd14;
            default: a = 18'd7;
        endcase
        return a;
    endfunction

endpackage

// ===== rtl/core/gsg_ctrl.sv =====
module gsg_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    input  gsg_pkg::t_sts i_sts,
    output gsg_pkg::t_cmd o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_RAW   = 11'b00000000010,
        S_COL   = 11'b00000000100,
        S_SUM   = 11'b00000001000,
        S_MUL   = 11'b00000010000,
        S_COR   = 11'b00000100000,
        S_BWR   = 11'b00001000000,
        S_SOB   = 11'b00010000000,
        S_CINIT = 11'b00100000000,
        S_CORD  = 11'b01000000000,
        S_FIN   = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   out_free;

    assign out_free = !r_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_RAW;
                end
            end
            S_RAW: begin
                o_cmd.raw_wr = 1'b1;
                if (i_sts.blur_on) begin
                    n_state = S_COL;
                end else begin
                    o_cmd.adv = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_COL: begin
                o_cmd.col = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_COR;
            end
            S_COR: begin
                o_cmd.cor = 1'b1;
                n_state   = S_BWR;
            end
            S_BWR: begin
                o_cmd.bwr = 1'b1;
                if (i_sts.sob_on) begin
                    n_state = S_SOB;
                end else begin
                    o_cmd.adv = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_SOB: begin
                o_cmd.sob = 1'b1;
                n_state   = S_CINIT;
            end
            S_CINIT: begin
                o_cmd.cinit = 1'b1;
                n_state     = S_CORD;
            end
            S_CORD: begin
                o_cmd.cord = 1'b1;
                if (i_sts.it_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.fin = 1'b1;
                    o_cmd.adv = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (o_cmd.fin) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

endmodule

// ===== rtl/core/gsg_dp.sv =====
module gsg_dp #(
    parameter int MAX_WIDTH  = gsg_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = gsg_pkg::MAX_HEIGHT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gsg_pkg::t_cmd      i_cmd,
    output gsg_pkg::t_sts      o_sts,
    input  logic               i_restart,
    input  logic [10:0]        i_frame_width,
    input  logic [15:0]        i_frame_height,
    input  logic               i_command,
    input  logic [7:0]         i_pixel,
    output logic [18:0]        o_magnitude,
    output logic signed [12:0] o_angle,
    output logic               o_last
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int TW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 3 * MAX_WIDTH + 4);
    localparam int CMPW = (WW > 11) ? WW : 11;
    localparam int RW   = gsg_pkg::ROW_W;

    // Effective frame size.
    logic [CMPW-1:0] fw_x;
    logic [WW-1:0]   w_eff;
    logic [15:0]     h_eff;

    assign fw_x = CMPW'(i_frame_width);

    always_comb begin
        if (i_frame_width == 11'd0) begin
            w_eff = WW'(1);
        end else if (fw_x > CMPW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(fw_x);
        end
        if (i_frame_height == 16'd0) begin
            h_eff = 16'd1;
        end else if (i_frame_height > 16'(MAX_HEIGHT)) begin
            h_eff = 16'(MAX_HEIGHT);
        end else begin
            h_eff = i_frame_height;
        end
    end

    // Stream position counters.
    logic [CW-1:0] r_c, r_xb, r_xs;
    logic [RW-1:0] r_r, r_yb;
    logic [15:0]   r_ys;
    logic [TW-1:0] r_t;
    logic          blur_on, sob_on;
    logic          c_wrap, xb_wrap, xs_wrap;
    logic          r_last;

    assign blur_on = r_t >= (TW'(w_eff) + TW'(w_eff) + TW'(2));
    assign sob_on  = r_t >= (TW'(w_eff) + TW'(w_eff) + TW'(w_eff) + TW'(3));
    assign c_wrap  = (WW'(r_c) + WW'(1)) == w_eff;
    assign xb_wrap = (WW'(r_xb) + WW'(1)) == w_eff;
    assign xs_wrap = (WW'(r_xs) + WW'(1)) == w_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart || (i_cmd.adv && r_last && sob_on)) begin
            r_c  <= '0;
            r_r  <= '0;
            r_t  <= '0;
            r_xb <= '0;
            r_yb <= '0;
            r_xs <= '0;
            r_ys <= '0;
        end else if (i_cmd.adv) begin
            r_t <= r_t + TW'(1);
            if (c_wrap) begin
                r_c <= '0;
                r_r <= r_r + RW'(1);
            end else begin
                r_c <= r_c + CW'(1);
            end
            if (blur_on) begin
                if (xb_wrap) begin
                    r_xb <= '0;
                    r_yb <= r_yb + RW'(1);
                end else begin
                    r_xb <= r_xb + CW'(1);
                end
            end
            if (sob_on) begin
                if (xs_wrap) begin
                    r_xs <= '0;
                    r_ys <= r_ys + 16'd1;
                end else begin
                    r_xs <= r_xs + CW'(1);
                end
            end
        end
    end

    // Input word capture.
    logic       r_in_cmd;
    logic [7:0] r_in_pix;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_in_cmd <= i_command;
            r_in_pix <= i_pixel;
        end
    end

    // Line stores: one word per column, one lane per stored row.
    logic [31:0] raw_mem  [MAX_WIDTH];
    logic [31:0] blur_mem [MAX_WIDTH];
    logic [31:0] r_raw_q, r_blur_q;
    logic [31:0] raw_wdata, blur_wdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_raw_q  <= raw_mem[r_c];
            r_blur_q <= blur_mem[r_xb];
        end
        if (i_cmd.raw_wr) begin
            raw_mem[r_c] <= raw_wdata;
        end
        if (i_cmd.bwr) begin
            blur_mem[r_xb] <= blur_wdata;
        end
    end

    // Raw column and window.
    logic [7:0] r_rw [5][5];
    logic [7:0] colv [5];
    logic [7:0] pix_v;
    logic [1:0] lane4;

    assign pix_v = (!r_in_cmd && (r_r < RW'(h_eff))) ? r_in_pix : 8'd0;

    always_comb begin
        raw_wdata = r_raw_q;
        raw_wdata[8 * r_r[1:0] +: 8] = pix_v;
        for (int e = 0; e < 4; e++) begin
            lane4 = r_r[1:0] + 2'(e);
            if (((RW + 1)'(r_r) + (RW + 1)'(e) >= (RW + 1)'(4)) &&
                ((RW + 1)'(r_r) + (RW + 1)'(e) < (RW + 1)'(h_eff) + (RW + 1)'(4))) begin
                colv[e] = r_raw_q[8 * lane4 +: 8];
            end else begin
                colv[e] = 8'd0;
            end
        end
        colv[4] = pix_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 5; k++) begin
                for (int e = 0; e < 5; e++) begin
                    r_rw[k][e] <= 8'd0;
                end
            end
        end else if (i_cmd.raw_wr) begin
            for (int k = 4; k > 0; k--) begin
                r_rw[k] <= r_rw[k - 1];
            end
            for (int e = 0; e < 5; e++) begin
                r_rw[0][e] <= colv[e];
            end
        end
    end

    // Gaussian: column sums, total, reciprocal multiply, correction.
    logic [13:0] col_sum [5];
    logic [13:0] r_cs [5];
    logic [15:0] r_g;
    logic [48:0] r_prod;
    logic [16:0] q0;
    logic [24:0] rem;
    logic [15:0] r_bq;
    logic [WW:0] xb_e;
    logic        col_ok;

    assign xb_e = (WW + 1)'(r_xb);

    always_comb begin
        for (int k = 0; k < 5; k++) begin
            if (k <= 2) begin
                col_ok = (xb_e + (WW + 1)'(2 - k)) < (WW + 1)'(w_eff);
            end else begin
                col_ok = xb_e >= (WW + 1)'(k - 2);
            end
            col_sum[k] = 14'd0;
            if (col_ok) begin
                for (int e = 0; e < 5; e++) begin
                    col_sum[k] = col_sum[k] + 14'(gsg_pkg::gauss_w(e, k) * r_rw[k][e]);
                end
            end
        end
    end

    assign q0  = r_prod[48:32];
    assign rem = 25'({r_g, 8'd79}) - 25'(q0 * gsg_pkg::DIV_159);

    always_ff @(posedge i_clk) begin
        if (i_cmd.col) begin
            r_cs <= col_sum;
        end
        if (i_cmd.sum) begin
            r_g <= 16'(r_cs[0]) + 16'(r_cs[1]) + 16'(r_cs[2]) + 16'(r_cs[3])
                   + 16'(r_cs[4]);
        end
        if (i_cmd.mul) begin
            r_prod <= 49'({r_g, 8'd79}) * 49'(gsg_pkg::RECIP_159);
        end
        if (i_cmd.cor) begin
            r_bq <= (rem >= 25'(gsg_pkg::DIV_159)) ? 16'(q0 + 17'd1) : 16'(q0);
        end
    end

    // Blur column and window.
    logic [15:0] bc [3];
    logic [15:0] r_bw [3][3];
    logic        lane2;

    always_comb begin
        for (int e = 0; e < 2; e++) begin
            lane2 = r_yb[0] ^ e[0];
            if (((RW + 1)'(r_yb) + (RW + 1)'(e) >= (RW + 1)'(2)) &&
                ((RW + 1)'(r_yb) + (RW + 1)'(e) < (RW + 1)'(h_eff) + (RW + 1)'(2))) begin
                bc[e] = r_blur_q[16 * lane2 +: 16];
            end else begin
                bc[e] = 16'd0;
            end
        end
        bc[2] = (r_yb < RW'(h_eff)) ? r_bq : 16'd0;
        blur_wdata = r_blur_q;
        blur_wdata[16 * r_yb[0] +: 16] = bc[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                for (int e = 0; e < 3; e++) begin
                    r_bw[k][e] <= 16'd0;
                end
            end
        end else if (i_cmd.bwr) begin
            r_bw[2] <= r_bw[1];
            r_bw[1] <= r_bw[0];
            for (int e = 0; e < 3; e++) begin
                r_bw[0][e] <= bc[e];
            end
        end
    end

    // Sobel sums.
    logic signed [19:0] val [3][3];
    logic signed [19:0] s1, s2;
    logic signed [19:0] r_s1, r_s2;
    logic [WW:0]        xs_e;
    logic               sob_ok;

    assign xs_e = (WW + 1)'(r_xs);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (k == 0) begin
                sob_ok = (xs_e + (WW + 1)'(1)) < (WW + 1)'(w_eff);
            end else if (k == 1) begin
                sob_ok = 1'b1;
            end else begin
                sob_ok = xs_e >= (WW + 1)'(1);
            end
            for (int e = 0; e < 3; e++) begin
                val[k][e] = sob_ok ? $signed({4'd0, r_bw[k][e]}) : 20'sd0;
            end
        end
        s1 = (val[0][2] - val[0][0]) + ((val[1][2] - val[1][0]) <<< 1)
             + (val[2][2] - val[2][0]);
        s2 = (val[0][0] - val[2][0]) + ((val[0][1] - val[2][1]) <<< 1)
             + (val[0][2] - val[2][2]);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sob) begin
            r_s1   <= s1;
            r_s2   <= s2;
            r_last <= (r_ys == h_eff - 16'd1) && xs_wrap;
        end
    end

    // Angle: CORDIC vectoring, one iteration per cycle.
    logic signed [29:0] r_x, r_y, x0, y0;
    logic signed [21:0] r_acc;
    logic [3:0]         r_it;
    logic               r_zero;
    logic signed [29:0] dx, dy;
    logic signed [21:0] ang_step;

    assign x0       = 30'(r_s1) <<< 8;
    assign y0       = 30'(r_s2) <<< 8;
    assign dx       = r_y >>> r_it;
    assign dy       = r_x >>> r_it;
    assign ang_step = $signed({4'd0, gsg_pkg::atan_tab(r_it)});

    always_ff @(posedge i_clk) begin
        if (i_cmd.cinit) begin
            r_zero <= (r_s1 == 20'sd0) && (r_s2 == 20'sd0);
            r_it   <= 4'd0;
            if (x0 < 0) begin
                if (y0 >= 0) begin
                    r_x   <= y0;
                    r_y   <= -x0;
                    r_acc <= gsg_pkg::ANG_Q90;
                end else begin
                    r_x   <= -y0;
                    r_y   <= x0;
                    r_acc <= -gsg_pkg::ANG_Q90;
                end
            end else begin
                r_x   <= x0;
                r_y   <= y0;
                r_acc <= 22'sd0;
            end
        end else if (i_cmd.cord) begin
            r_it <= r_it + 4'd1;
            if (r_y >= 0) begin
                r_x   <= r_x + dx;
                r_y   <= r_y - dy;
                r_acc <= r_acc + ang_step;
            end else begin
                r_x   <= r_x - dx;
                r_y   <= r_y + dy;
                r_acc <= r_acc - ang_step;
            end
        end
    end

    // Rounding, clamp and magnitude into the output register.
    logic signed [21:0] acc_abs, acc_rnd;
    logic signed [13:0] ang_r;
    logic signed [12:0] ang_c;
    logic [18:0]        mag;

    always_comb begin
        acc_abs = (r_acc < 0) ? -r_acc : r_acc;
        acc_rnd = (acc_abs + 22'sd128) >>> 8;
        ang_r   = (r_acc < 0) ? -14'(acc_rnd) : 14'(acc_rnd);
        if (r_zero) begin
            ang_c = 13'sd0;
        end else if (ang_r > 14'(gsg_pkg::ANG_MAX)) begin
            ang_c = gsg_pkg::ANG_MAX;
        end else if (ang_r < -14'(gsg_pkg::ANG_MAX)) begin
            ang_c = -gsg_pkg::ANG_MAX;
        end else begin
            ang_c = 13'(ang_r);
        end
        mag = 19'((r_s1 < 0) ? -r_s1 : r_s1) + 19'((r_s2 < 0) ? -r_s2 : r_s2);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            o_magnitude <= mag;
            o_angle     <= ang_c;
            o_last      <= r_last;
        end
    end

    assign o_sts.blur_on = blur_on;
    assign o_sts.sob_on  = sob_on;
    assign o_sts.it_done = (r_it == 4'd15);

endmodule

// ===== rtl/core/gaussian_sobel_gradient_top.sv =====
// Latency: a result word leaves 3*W+3 input words after its pixel (W = row width);
// an input word passes the read and raw-write steps if it yields no blur value, adds the
// column, sum, multiply, correction and blur-write steps if it yields a blur value only,
// and then the Sobel, CORDIC set-up, CORDIC and finish steps if it yields a result; the
// result may wait for the output register, and no new word is taken until it is through.
// Reset (synchronous, active low) restores both size registers to 1024, clears the
// position counters and the filter windows; the line stores are not cleared.
module gaussian_sobel_gradient_top #(
    parameter int MAX_WIDTH  = gsg_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = gsg_pkg::MAX_HEIGHT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input channel.
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_command,
    input  logic [7:0]         i_pixel,
    // Output channel.
    output logic               o_valid,
    input  logic               i_ready,
    output logic [18:0]        o_magnitude,
    output logic signed [12:0] o_angle,
    output logic               o_last,
    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // The two size registers sit here. A write to either one restarts the
    // frame position in the datapath, while the windows keep their contents.
    logic [10:0]      r_frame_width;
    logic [15:0]      r_frame_height;
    logic             cfg_wr;
    gsg_pkg::t_reg_idx cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = gsg_pkg::t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= gsg_pkg::WIDTH_RESET;
            r_frame_height <= gsg_pkg::HEIGHT_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                gsg_pkg::REG_FRAME_WIDTH:  r_frame_width  <= pwdata[10:0];
                gsg_pkg::REG_FRAME_HEIGHT: r_frame_height <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            gsg_pkg::REG_FRAME_WIDTH:  prdata = {21'd0, r_frame_width};
            gsg_pkg::REG_FRAME_HEIGHT: prdata = {16'd0, r_frame_height};
            default:                   prdata = 32'd0;
        endcase
    end

    // The controller walks one word through the read, blur, Sobel and CORDIC
    // steps; the datapath holds the line stores, windows and arithmetic.
    gsg_pkg::t_cmd cmd;
    gsg_pkg::t_sts sts;

    gsg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    gsg_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_restart      (cfg_wr),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_command      (i_command),
        .i_pixel        (i_pixel),
        .o_magnitude    (o_magnitude),
        .o_angle        (o_angle),
        .o_last         (o_last)
    );

    // A word that has just been taken keeps the input closed for the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input accepted twice in a row");

    // A flat neighborhood yields a zero angle.
    a_zero_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_magnitude == 19'd0)) |-> (o_angle == 13'sd0))
        else $error("nonzero angle with zero magnitude");

    // The angle stays inside its clamp.
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_angle <= gsg_pkg::ANG_MAX) && (o_angle >= -gsg_pkg::ANG_MAX)))
        else $error("angle out of range");

endmodule
